// ----- hdl/rgc_pkg.sv -----
package rgc_pkg;

  // Pixel and result widths.
  localparam int PIX_W    = 8;
  localparam int WGT_W    = 8;
  localparam int PROD_W   = 17;
  localparam int RSUM_W   = 19;
  localparam int SUM_W    = 21;
  localparam int FILT_W   = 20;
  localparam int IW_W     = 11;
  localparam int KREG_W   = 24;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Division by three as a multiply by a scaled reciprocal; exact for sums up to 765.
  localparam int GRAY_RECIP = 683;
  localparam int GRAY_SHIFT = 11;
  localparam int GRAY_PW    = 19;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_KERNEL_TOP    = 2'd1,
    REG_KERNEL_MIDDLE = 2'd2,
    REG_KERNEL_BOTTOM = 2'd3
  } reg_idx_t;

  // Kernel weights indexed [row][column]; row 0 is the top, column 0 the left.
  typedef logic [2:0][2:0][WGT_W-1:0] kern_t;

  // One window column: index 0 top (oldest row), 1 middle, 2 bottom (current pixel).
  typedef logic [2:0][PIX_W-1:0] pix3_t;

  // Stage item handed from the column stage to the filter datapath.
  typedef struct packed {
    pix3_t col;
    logic  emit;
    logic  last;
  } col_item_t;

  // Gray value of one pixel: channel sum divided by three, truncated.
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
    logic [GRAY_PW-1:0] s;
    logic [GRAY_PW-1:0] p;
    s = GRAY_PW'(b) + GRAY_PW'(g) + GRAY_PW'(r);
    p = s * GRAY_PW'(GRAY_RECIP);
    return p[GRAY_SHIFT +: PIX_W];
  endfunction

  // Unsigned pixel times signed weight, both extended to the product width first.
  function automatic logic signed [PROD_W-1:0] mul_px(input logic [PIX_W-1:0] pix,
                                                      input logic [WGT_W-1:0] wgt);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] w;
    p = $signed({{(PROD_W-PIX_W){1'b0}}, pix});
    w = PROD_W'($signed(wgt));
    return p * w;
  endfunction

endpackage

// ----- hdl/rgc_cfg.sv -----
module rgc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgc_pkg::CFG_AW-1:0]    paddr,
  input  logic [rgc_pkg::CFG_DW-1:0]    pwdata,
  output logic [rgc_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [rgc_pkg::IW_W-1:0]      image_width,
  output rgc_pkg::kern_t                kern
);

  logic [rgc_pkg::IW_W-1:0]   width_r;
  logic [rgc_pkg::KREG_W-1:0] ktop_r;
  logic [rgc_pkg::KREG_W-1:0] kmid_r;
  logic [rgc_pkg::KREG_W-1:0] kbot_r;
  rgc_pkg::reg_idx_t          idx;
  logic                       wr_en;

  assign idx    = rgc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= rgc_pkg::IW_W'(1024);
      ktop_r  <= '0;
      kmid_r  <= '0;
      kbot_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        rgc_pkg::REG_IMAGE_WIDTH:   width_r <= pwdata[rgc_pkg::IW_W-1:0];
        rgc_pkg::REG_KERNEL_TOP:    ktop_r  <= pwdata[rgc_pkg::KREG_W-1:0];
        rgc_pkg::REG_KERNEL_MIDDLE: kmid_r  <= pwdata[rgc_pkg::KREG_W-1:0];
        rgc_pkg::REG_KERNEL_BOTTOM: kbot_r  <= pwdata[rgc_pkg::KREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      rgc_pkg::REG_IMAGE_WIDTH:   prdata = rgc_pkg::CFG_DW'(width_r);
      rgc_pkg::REG_KERNEL_TOP:    prdata = rgc_pkg::CFG_DW'(ktop_r);
      rgc_pkg::REG_KERNEL_MIDDLE: prdata = rgc_pkg::CFG_DW'(kmid_r);
      rgc_pkg::REG_KERNEL_BOTTOM: prdata = rgc_pkg::CFG_DW'(kbot_r);
      default:                    prdata = '0;
    endcase
  end

  assign image_width = width_r;
  assign kern[0]     = ktop_r;
  assign kern[1]     = kmid_r;
  assign kern[2]     = kbot_r;

endmodule

// ----- hdl/rgc_line_mem.sv -----
module rgc_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] q_r;
  logic          byp_r;
  logic [DW-1:0] byp_data_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // A read that hits the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

// ----- hdl/rgc_mac.sv -----
module rgc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  rgc_pkg::col_item_t                item,
  output logic                              ready,
  input  rgc_pkg::kern_t                    kern,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rgc_pkg::FILT_W-1:0] filtered,
  output logic                              row_end
);

  // Two previous columns per window row: [row][0] oldest, [row][1] newer.
  logic [2:0][1:0][rgc_pkg::PIX_W-1:0]      win_r;
  logic signed [rgc_pkg::PROD_W-1:0]        prod_nxt [3][3];
  logic signed [rgc_pkg::PROD_W-1:0]        prod_r   [3][3];
  logic signed [rgc_pkg::RSUM_W-1:0]        rsum_nxt [3];
  logic signed [rgc_pkg::RSUM_W-1:0]        rsum_r   [3];
  logic signed [rgc_pkg::SUM_W-1:0]         sum_nxt;
  logic                                     p_vld_r;
  logic                                     p_last_r;
  logic                                     s_vld_r;
  logic                                     s_last_r;
  logic                                     o_vld_r;
  logic                                     o_last_r;
  logic signed [rgc_pkg::FILT_W-1:0]        o_filt_r;
  logic                                     o_free;
  logic                                     s_free;
  logic                                     p_free;

  assign o_free = !o_vld_r || out_ready;
  assign s_free = !s_vld_r || o_free;
  assign p_free = !p_vld_r || s_free;
  assign ready  = p_free;

  // The window shifts by one column for every pixel that passes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (step) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= item.col[r];
      end
    end
  end

  // Nine products of the current window and the kernel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[r][0] = rgc_pkg::mul_px(win_r[r][0], kern[r][0]);
      prod_nxt[r][1] = rgc_pkg::mul_px(win_r[r][1], kern[r][1]);
      prod_nxt[r][2] = rgc_pkg::mul_px(item.col[r], kern[r][2]);
    end
  end

  // Row sums, then the total.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_nxt[r] = rgc_pkg::RSUM_W'(prod_r[r][0]) + rgc_pkg::RSUM_W'(prod_r[r][1])
                  + rgc_pkg::RSUM_W'(prod_r[r][2]);
    end
    sum_nxt = rgc_pkg::SUM_W'(rsum_r[0]) + rgc_pkg::SUM_W'(rsum_r[1])
            + rgc_pkg::SUM_W'(rsum_r[2]);
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_vld_r <= step && item.emit;
      end
      if (s_free) begin
        s_vld_r <= p_vld_r;
      end
      if (o_free) begin
        o_vld_r <= s_vld_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (p_free && step && item.emit) begin
      prod_r   <= prod_nxt;
      p_last_r <= item.last;
    end
    if (s_free && p_vld_r) begin
      rsum_r   <= rsum_nxt;
      s_last_r <= p_last_r;
    end
    if (o_free && s_vld_r) begin
      o_filt_r <= sum_nxt[rgc_pkg::FILT_W-1:0];
      o_last_r <= s_last_r;
    end
  end

  assign out_valid = o_vld_r;
  assign filtered  = o_filt_r;
  assign row_end   = o_last_r;

endmodule

// ----- hdl/rgb_gray_conv3x3_unit.sv -----
// Channel   Dir  Beat fields
// in_*      in   tdata: blue, green, red; tuser: start_of_frame
// out_*     out  tdata: filtered (20-bit signed, zero padded); tlast: row_end
// APB       in   image_width, kernel_top, kernel_middle, kernel_bottom
//
// One pixel beat is accepted per clock while no stall holds in_tready low; a result leaves
// through the column, product, row sum and output registers. The rate is set by the single
// read and single write port of the line memory, which each see one access per pixel.
// Synchronous active-low reset clears the counters, window and valid flags;
// the line memory is not cleared, and results are emitted only from the third row on.
// A stall on out_tready backs up through the filter stages to in_tready.
module rgb_gray_conv3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // blue, green, red
  input  logic                       in_tuser,   // start_of_frame
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // filtered, zero fill
  output logic                       out_tlast,  // row_end
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgc_pkg::CFG_AW-1:0] paddr,
  input  logic [rgc_pkg::CFG_DW-1:0] pwdata,
  output logic [rgc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > rgc_pkg::IW_W) ? CW + 1 : rgc_pkg::IW_W;
  localparam int MW = 2 * rgc_pkg::PIX_W;
  localparam logic [1:0] ROW_FULL = 2'd2;

  logic [rgc_pkg::IW_W-1:0]          image_width;
  rgc_pkg::kern_t                    kern;
  logic [CW-1:0]                     col_r;
  logic [1:0]                        row_r;
  logic [CW-1:0]                     c_in;
  logic [1:0]                        row_in;
  logic [XW-1:0]                     iw_x;
  logic [XW-1:0]                     w_use;
  logic                              last_in;
  logic                              emit_in;
  logic                              in_acc;
  logic                              a_vld_r;
  logic [rgc_pkg::PIX_W-1:0]         a_gray_r;
  logic [CW-1:0]                     a_col_r;
  logic                              a_emit_r;
  logic                              a_last_r;
  logic                              a_adv;
  logic                              mac_ready;
  logic [MW-1:0]                     mem_rd;
  rgc_pkg::col_item_t                a_item;
  logic signed [rgc_pkg::FILT_W-1:0] filt;

  rgc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .image_width (image_width),
    .kern        (kern)
  );

  // Width in use, clamped to 3..MAX_WIDTH.
  assign iw_x  = XW'(image_width);
  assign w_use = (iw_x < XW'(3)) ? XW'(3) :
                 (iw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : iw_x;

  // Position of the incoming pixel; start of frame restarts at row 0, column 0.
  assign c_in    = in_tuser ? '0 : col_r;
  assign row_in  = in_tuser ? '0 : row_r;
  assign last_in = (XW'(c_in) + XW'(1)) >= w_use;
  assign emit_in = (row_in == ROW_FULL) && (c_in >= CW'(2));

  // Column stage handshake.
  assign a_adv     = a_vld_r && (!a_emit_r || mac_ready);
  assign in_tready = !a_vld_r || a_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= last_in ? '0 : c_in + CW'(1);
      row_r <= (last_in && row_in != ROW_FULL) ? row_in + 2'd1 : row_in;
    end
  end

  // Column stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tready) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_gray_r <= rgc_pkg::gray_of(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      a_col_r  <= c_in;
      a_emit_r <= emit_in;
      a_last_r <= last_in;
    end
  end

  // Line memory: high byte is two rows back, low byte the previous row.
  rgc_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (MW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_in),
    .wr_en   (a_adv),
    .wr_addr (a_col_r),
    .wr_data ({mem_rd[rgc_pkg::PIX_W-1:0], a_gray_r}),
    .rd_data (mem_rd)
  );

  assign a_item.col[0] = mem_rd[MW-1:rgc_pkg::PIX_W];
  assign a_item.col[1] = mem_rd[rgc_pkg::PIX_W-1:0];
  assign a_item.col[2] = a_gray_r;
  assign a_item.emit   = a_emit_r;
  assign a_item.last   = a_last_r;

  rgc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (a_adv),
    .item      (a_item),
    .ready     (mac_ready),
    .kern      (kern),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .filtered  (filt),
    .row_end   (out_tlast)
  );

  assign out_tdata = {{(24 - rgc_pkg::FILT_W){1'b0}}, filt};

  // A start-of-frame pixel always lands in column 0.
  a_sof_col0: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> a_col_r == '0)
    else $error("start of frame pixel not placed in column 0");

  // A row can only end once three columns have been seen.
  a_last_min: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && a_last_r |-> a_col_r >= CW'(2))
    else $error("row ended before column 2");

  // Without a frame restart, neighboring pixels never share a line memory entry.
  a_no_addr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && a_adv && !in_tuser |-> c_in != a_col_r)
    else $error("back-to-back pixels map to the same line entry");

  // A pixel that emits sits in the third row or below.
  a_emit_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit_in |-> (row_r == ROW_FULL) && !in_tuser)
    else $error("window emitted before two full rows");

endmodule

// ----- verif/tb_rgb_gray_conv3x3_unit.sv -----
module tb_rgb_gray_conv3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W      = 1024;
  localparam int IDLE_LIMIT = 3000;
  localparam int FLUSH_CYC  = 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       sof;
  } pixel_t;

  typedef struct packed {
    logic [rgc_pkg::FILT_W-1:0] filtered;
    logic                       row_end;
  } conv_out_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [23:0]                in_tdata   = '0;  // blue, green, red
  logic                       in_tuser   = 1'b0; // start_of_frame
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [23:0]                out_tdata;  // filtered, zero fill
  logic                       out_tlast;  // row_end
  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [rgc_pkg::CFG_AW-1:0] paddr      = '0;
  logic [rgc_pkg::CFG_DW-1:0] pwdata     = '0;
  logic [rgc_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  rgb_gray_conv3x3_unit #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Pixel backlog, expected sums and bookkeeping.
  pixel_t    pixel_backlog[$];
  conv_out_t sums_expected[$];
  int        pixels_pushed   = 0;
  int        pixels_accepted = 0;
  int        sums_seen       = 0;
  int        mismatch_cnt    = 0;

  // Shadow of the block's registers and state.
  logic [rgc_pkg::IW_W-1:0]   width_reg = 11'd1024;
  logic [rgc_pkg::KREG_W-1:0] kern[3]   = '{24'h0, 24'h0, 24'h0};
  logic [7:0]                 prev_row[MAX_W];
  logic [7:0]                 older_row[MAX_W];
  logic [7:0]                 win[6]    = '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0};
  int                         col_cnt   = 0;
  int                         row_cnt   = 0;

  function automatic int clamp_width(input int w);
    if (w < 3) return 3;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // Gray conversion, line stores and 3x3 weighted sum for one pixel.
  task automatic predict_pixel(input pixel_t p);
    int               w, c, s, pv, wv;
    logic [7:0]       gray;
    logic [7:0]       colv[3];
    logic signed [7:0] wgt;
    logic             last;
    conv_out_t        e;
    w = clamp_width(int'(width_reg));
    if (p.sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    gray = 8'((int'(p.blue) + int'(p.green) + int'(p.red)) / 3);
    c = col_cnt;
    if (c >= MAX_W) c = 0;
    colv[0] = older_row[c];
    colv[1] = prev_row[c];
    colv[2] = gray;
    older_row[c] = colv[1];
    prev_row[c] = gray;
    last = (c + 1 >= w);
    if (row_cnt >= 2 && c >= 2) begin
      s = 0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          wgt = kern[r][8*k +: 8];
          wv = wgt;
          pv = (k == 2) ? colv[r] : win[r*2 + k];
          s += pv * wv;
        end
      end
      e.filtered = s[rgc_pkg::FILT_W-1:0];
      e.row_end = last;
      sums_expected.push_back(e);
    end
    for (int r = 0; r < 3; r++) begin
      win[r*2] = win[r*2 + 1];
      win[r*2 + 1] = colv[r];
    end
    if (last) begin
      col_cnt = 0;
      if (row_cnt < 2) row_cnt++;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // Pixel driver: bursts of random length separated by random gaps.
  int     gap_left   = 0;
  int     burst_left = 0;
  pixel_t drv_pix;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pixel({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tuser});
        pixels_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pixel_backlog.size() > 0) begin
          drv_pix = pixel_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {drv_pix.red, drv_pix.green, drv_pix.blue};
          in_tuser <= drv_pix.sof;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall pattern changes over time, plus one long hold-off.
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && sums_seen >= 40 && pixel_backlog.size() > 50) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checker against the oldest expected sum.
  conv_out_t mon_exp;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sums_seen++;
      if (sums_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        mon_exp = sums_expected.pop_front();
        if (out_tdata[rgc_pkg::FILT_W-1:0] !== mon_exp.filtered ||
            out_tdata[23:rgc_pkg::FILT_W] !== '0 ||
            out_tlast !== mon_exp.row_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected filtered=%h row_end=%b, got tdata=%h tlast=%b",
                     sums_seen, mon_exp.filtered, mon_exp.row_end, out_tdata, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles in which no beat and no register access happen.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input rgc_pkg::reg_idx_t idx,
                           input logic [rgc_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rgc_pkg::REG_IMAGE_WIDTH:   width_reg = val[rgc_pkg::IW_W-1:0];
      rgc_pkg::REG_KERNEL_TOP:    kern[0] = val[rgc_pkg::KREG_W-1:0];
      rgc_pkg::REG_KERNEL_MIDDLE: kern[1] = val[rgc_pkg::KREG_W-1:0];
      default:                    kern[2] = val[rgc_pkg::KREG_W-1:0];
    endcase
  endtask

  task automatic set_kernels(input logic [23:0] k0, input logic [23:0] k1,
                             input logic [23:0] k2);
    cfg_write(rgc_pkg::REG_KERNEL_TOP, 32'(k0));
    cfg_write(rgc_pkg::REG_KERNEL_MIDDLE, 32'(k1));
    cfg_write(rgc_pkg::REG_KERNEL_BOTTOM, 32'(k2));
  endtask

  // Wait until every pixel is taken and every sum has arrived, then let the pipe empty.
  task automatic wait_drained();
    while (pixels_accepted != pixels_pushed || sums_expected.size() != 0) @(posedge clk);
    repeat (FLUSH_CYC) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic sof);
    pixel_backlog.push_back({b, g, r, sof});
    pixels_pushed++;
  endtask

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] rand_kernel();
    case ($urandom_range(0, 9))
      0: return 24'h7F7F7F;
      1: return 24'h808080;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Random pixels, with an occasional stray start-of-frame flag as noise.
  task automatic push_random(input int n);
    for (int i = 0; i < n; i++)
      push_pixel(rand_channel(), rand_channel(), rand_channel(), ($urandom_range(0, 199) == 0));
  endtask

  task automatic push_frame(input int len);
    push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b1);
    push_random(len - 1);
  endtask

  int rand_sent;
  int w_set, w_eff, len;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Width below range clamps to three; largest positive weights; gray truncation edges.
    set_kernels(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd2);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd0, 1'b0);
    push_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd2, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    wait_drained();

    // Most negative weights, zero width, and a frame restarted part way in.
    set_kernels(24'h808080, 24'h808080, 24'h808080);
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd0);
    for (int i = 0; i < 3; i++) push_pixel(8'd255, 8'd255, 8'd255, (i == 0));
    for (int i = 0; i < 9; i++) push_pixel(8'd255, 8'd255, 8'd255, (i == 0));
    wait_drained();

    // Width shrunk inside a frame: the first pixel past the new last column ends its row.
    set_kernels(rand_kernel(), rand_kernel(), rand_kernel());
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd8);
    push_frame(3 * 8 + 6);
    wait_drained();
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd4);
    for (int i = 0; i < 10; i++) push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    wait_drained();

    // Random phases: mostly narrow frames, some wider, some broken off early.
    rand_sent = 0;
    while (rand_sent < 1250) begin
      case ($urandom_range(0, 9))
        0: w_set = $urandom_range(0, 2);
        1: w_set = $urandom_range(33, 80);
        default: w_set = $urandom_range(3, 12);
      endcase
      w_eff = clamp_width(w_set);
      cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'(w_set));
      if ($urandom_range(0, 1) != 0) cfg_write(rgc_pkg::REG_KERNEL_TOP, 32'(rand_kernel()));
      if ($urandom_range(0, 1) != 0) cfg_write(rgc_pkg::REG_KERNEL_MIDDLE, 32'(rand_kernel()));
      if ($urandom_range(0, 1) != 0) cfg_write(rgc_pkg::REG_KERNEL_BOTTOM, 32'(rand_kernel()));
      for (int f = $urandom_range(1, 2); f > 0; f--) begin
        len = w_eff * $urandom_range(3, 5) + $urandom_range(0, w_eff - 1);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
        push_frame(len);
        rand_sent += len;
      end
      wait_drained();
    end

    // A whole frame queued at once, so the long receiver hold-off fills the block.
    set_kernels(rand_kernel(), rand_kernel(), rand_kernel());
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd8);
    push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b1);
    for (int i = 1; i < 8 * 8; i++)
      push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    wait_drained();

    // Width above range clamps to the line store size; a short frame stays in its first row.
    cfg_write(rgc_pkg::REG_IMAGE_WIDTH, 32'd2047);
    push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b1);
    for (int i = 1; i < 40; i++)
      push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && sums_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rgc_pkg.sv
hdl/rgc_cfg.sv
hdl/rgc_line_mem.sv
hdl/rgc_mac.sv
hdl/rgb_gray_conv3x3_unit.sv
verif/tb_rgb_gray_conv3x3_unit.sv
